>>> design/uv_sphere_point_and_quad_defines.svh
// Assertion macros shared by the sphere point and quad generator.
`ifndef UV_SPHERE_POINT_AND_QUAD_DEFINES_SVH
`define UV_SPHERE_POINT_AND_QUAD_DEFINES_SVH
`ifndef SYNTHESIS
`define USP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define USP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define USP_ASSERT(lbl, clk, rst_n, prop, msg)
`define USP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/usp_pkg.sv
// Shared types, constants and latencies of the sphere point and quad generator.
`default_nettype none
package usp_pkg;

    // Grid and coordinate format.
    localparam int GRID_LIMIT      = 256;
    localparam int COORD_FRAC_BITS = 15;
    localparam int COORD_BITS      = 16;
    localparam int COUNT_BITS      = 9;
    localparam int POS_BITS        = 8;
    localparam int INDEX_BITS      = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_RINGS   = 2'd0;
    localparam logic [1:0] REG_SECTORS = 2'd1;
    localparam logic [COUNT_BITS-1:0] RINGS_RESET   = 9'd16;
    localparam logic [COUNT_BITS-1:0] SECTORS_RESET = 9'd16;

    // Phase division.
    localparam int PHASE_BITS          = 32;
    localparam int DIV_BITS_PER_STAGE  = 4;
    localparam int DIV_STAGES          = PHASE_BITS / DIV_BITS_PER_STAGE;
    localparam int LAT_DIV             = DIV_STAGES + 1;

    // Q30 arithmetic of the sine and cosine kernel.
    localparam int Q30_BITS  = 30;
    localparam int TRIG_BITS = 32;
    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF = 64'd1 << 29;
    localparam logic [63:0] TWO_POW_32 = 64'd1 << 32;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam int STEP_LAT  = 4;
    localparam int SIN_LAT   = SIN_STEPS * STEP_LAT;
    localparam int COS_LAT   = COS_STEPS * STEP_LAT;
    localparam int SIN_PAD   = COS_LAT - SIN_LAT - 2;
    localparam int LAT_SC    = 5 + COS_LAT + 1;

    localparam logic [7:0] SIN_K [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_K [COS_STEPS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_M [SIN_STEPS] = '{
        32'(TWO_POW_32 / 110), 32'(TWO_POW_32 / 72), 32'(TWO_POW_32 / 42),
        32'(TWO_POW_32 / 20), 32'(TWO_POW_32 / 6)};
    localparam logic [31:0] COS_M [COS_STEPS] = '{
        32'(TWO_POW_32 / 132), 32'(TWO_POW_32 / 90), 32'(TWO_POW_32 / 56),
        32'(TWO_POW_32 / 30), 32'(TWO_POW_32 / 12), 32'(TWO_POW_32 / 2)};

    // Quadrant codes of a phase.
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    // Coordinate rounding.
    localparam int XZ_SHIFT = 2 * Q30_BITS - COORD_FRAC_BITS;
    localparam int Y_SHIFT  = Q30_BITS - COORD_FRAC_BITS;
    localparam int LAT_CRD  = 2;

    // Stages from the input register to the last pipeline stage.
    localparam int LAT_SIDE = LAT_DIV + LAT_SC + LAT_CRD;

    typedef struct packed {
        logic [POS_BITS-1:0] ring;
        logic [POS_BITS-1:0] sector;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [INDEX_BITS-1:0] index_a;
        logic [INDEX_BITS-1:0] index_b;
        logic [INDEX_BITS-1:0] index_c;
        logic [INDEX_BITS-1:0] index_d;
        logic [INDEX_BITS-1:0] index_e;
        logic [INDEX_BITS-1:0] index_f;
        logic quad_valid;
        logic out_of_grid;
    } t_out_item;

endpackage
`default_nettype wire

>>> design/usp_phase_div.sv
// Pipelined restoring divider that turns a grid position into a rounded 32-bit phase.
`default_nettype none
module usp_phase_div import usp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [POS_BITS-1:0]   i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    input  logic [COUNT_BITS-1:0] i_half,
    output logic [PHASE_BITS-1:0] o_phase
);

    logic [COUNT_BITS-1:0] r_rem  [DIV_STAGES];
    logic [PHASE_BITS-1:0] r_quo  [DIV_STAGES];
    logic [COUNT_BITS-1:0] r_den  [DIV_STAGES];
    logic [COUNT_BITS-1:0] r_half [DIV_STAGES];
    logic [PHASE_BITS-1:0] r_phase;

    logic [COUNT_BITS-1:0] n_rem_in  [DIV_STAGES];
    logic [PHASE_BITS-1:0] n_quo_in  [DIV_STAGES];
    logic [COUNT_BITS-1:0] n_den_in  [DIV_STAGES];
    logic [COUNT_BITS-1:0] n_half_in [DIV_STAGES];
    logic [COUNT_BITS-1:0] n_rem     [DIV_STAGES];
    logic [PHASE_BITS-1:0] n_quo     [DIV_STAGES];

    // Stage inputs: a numerator equal to the divisor is a full turn, so its fraction is zero.
    always_comb begin
        n_rem_in[0]  = ({1'b0, i_num} == i_den) ? '0 : {1'b0, i_num};
        n_quo_in[0]  = '0;
        n_den_in[0]  = i_den;
        n_half_in[0] = i_half;
        for (int st = 1; st < DIV_STAGES; st++) begin
            n_rem_in[st]  = r_rem[st-1];
            n_quo_in[st]  = r_quo[st-1];
            n_den_in[st]  = r_den[st-1];
            n_half_in[st] = r_half[st-1];
        end
    end

    // A few quotient bits in each stage.
    always_comb begin
        logic [COUNT_BITS:0]   w;
        logic [COUNT_BITS-1:0] rem;
        logic [PHASE_BITS-1:0] quo;
        for (int st = 0; st < DIV_STAGES; st++) begin
            rem = n_rem_in[st];
            quo = n_quo_in[st];
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                w = {rem, 1'b0};
                if (w >= {1'b0, n_den_in[st]}) begin
                    rem = COUNT_BITS'(w - {1'b0, n_den_in[st]});
                    quo = {quo[PHASE_BITS-2:0], 1'b1};
                end else begin
                    rem = w[COUNT_BITS-1:0];
                    quo = {quo[PHASE_BITS-2:0], 1'b0};
                end
            end
            n_rem[st] = rem;
            n_quo[st] = quo;
        end
    end

    // Stage registers, then round half up by the remainder.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int st = 0; st < DIV_STAGES; st++) begin
                r_rem[st]  <= n_rem[st];
                r_quo[st]  <= n_quo[st];
                r_den[st]  <= n_den_in[st];
                r_half[st] <= n_half_in[st];
            end
            r_phase <= r_quo[DIV_STAGES-1] + PHASE_BITS'(
                ({1'b0, r_rem[DIV_STAGES-1]} + {1'b0, r_half[DIV_STAGES-1]})
                >= {1'b0, r_den[DIV_STAGES-1]});
        end
    end

    assign o_phase = r_phase;

endmodule
`default_nettype wire

>>> design/usp_sincos.sv
// Pipelined sine and cosine of a 32-bit phase by Horner series in Q30.
`default_nettype none
module usp_sincos import usp_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [PHASE_BITS-1:0]       i_phase,
    output logic signed [TRIG_BITS-1:0] o_sin,
    output logic signed [TRIG_BITS-1:0] o_cos
);

    typedef struct packed {
        logic [1:0]          quad;
        logic                swap;
        logic [Q30_BITS-1:0] rad;
    } t_sc_ctl;

    typedef struct packed {
        t_sc_ctl             ctl;
        logic [Q30_BITS-1:0] x2;
    } t_sc_tap;

    logic [Q30_BITS-1:0]   r_k0_f;
    t_sc_ctl               r_k0_ctl, r_k1_ctl, r_k2_ctl, r_k3_ctl;
    logic [2*Q30_BITS+1:0] r_k1_mr;
    logic [2*Q30_BITS-1:0] r_k3_rr;
    t_sc_tap               r_dl [COS_LAT+1];

    logic [2*Q30_BITS:0]   c_p1 [COS_STEPS];
    logic [Q30_BITS-1:0]   c_p  [COS_STEPS];
    logic [2*Q30_BITS+1:0] c_pm [COS_STEPS];
    logic [Q30_BITS-1:0]   c_pc [COS_STEPS];
    logic [Q30_BITS:0]     c_t  [COS_STEPS];

    logic [2*Q30_BITS:0]   s_p1 [SIN_STEPS];
    logic [Q30_BITS-1:0]   s_p  [SIN_STEPS];
    logic [2*Q30_BITS+1:0] s_pm [SIN_STEPS];
    logic [Q30_BITS-1:0]   s_pc [SIN_STEPS];
    logic [Q30_BITS:0]     s_t  [SIN_STEPS];

    logic [2*Q30_BITS:0]   r_s_mul;
    logic [Q30_BITS:0]     r_s_val;
    logic [Q30_BITS:0]     r_s_pad [SIN_PAD];
    logic signed [TRIG_BITS-1:0] r_sin, r_cos;

    logic [Q30_BITS-1:0] n_k0_f;
    logic [Q30_BITS:0]   n_ct_in [COS_STEPS];
    logic [Q30_BITS:0]   n_st_in [SIN_STEPS];
    logic [Q30_BITS-1:0] n_c_qe  [COS_STEPS];
    logic [Q30_BITS-1:0] n_c_rem [COS_STEPS];
    logic [Q30_BITS:0]   n_c_t   [COS_STEPS];
    logic [Q30_BITS-1:0] n_s_qe  [SIN_STEPS];
    logic [Q30_BITS-1:0] n_s_rem [SIN_STEPS];
    logic [Q30_BITS:0]   n_s_t   [SIN_STEPS];
    logic [Q30_BITS:0]   n_a, n_b, n_s0, n_c0;
    logic signed [TRIG_BITS-1:0] n_s0s, n_c0s, n_sin, n_cos;
    t_sc_ctl             n_qctl;

    // Fold the offset within a quadrant onto the first octant.
    always_comb begin
        n_k0_f = i_phase[Q30_BITS-1]
            ? Q30_BITS'(Q30_ONE - 64'(i_phase[Q30_BITS-1:0]))
            : i_phase[Q30_BITS-1:0];
    end

    // Term inputs of each Horner step, and the exact division by its constant.
    always_comb begin
        n_ct_in[0] = (Q30_BITS+1)'(Q30_ONE);
        n_st_in[0] = (Q30_BITS+1)'(Q30_ONE);
        for (int j = 1; j < COS_STEPS; j++) n_ct_in[j] = c_t[j-1];
        for (int j = 1; j < SIN_STEPS; j++) n_st_in[j] = s_t[j-1];
        for (int j = 0; j < COS_STEPS; j++) begin
            n_c_qe[j]  = Q30_BITS'(c_pm[j] >> 32);
            n_c_rem[j] = c_pc[j] - Q30_BITS'(n_c_qe[j] * COS_K[j]);
            n_c_t[j]   = (Q30_BITS+1)'(Q30_ONE) - {1'b0, n_c_qe[j]}
                       - {{Q30_BITS{1'b0}}, n_c_rem[j] >= Q30_BITS'(COS_K[j])};
        end
        for (int j = 0; j < SIN_STEPS; j++) begin
            n_s_qe[j]  = Q30_BITS'(s_pm[j] >> 32);
            n_s_rem[j] = s_pc[j] - Q30_BITS'(n_s_qe[j] * SIN_K[j]);
            n_s_t[j]   = (Q30_BITS+1)'(Q30_ONE) - {1'b0, n_s_qe[j]}
                       - {{Q30_BITS{1'b0}}, n_s_rem[j] >= Q30_BITS'(SIN_K[j])};
        end
    end

    // Quadrant: undo the fold, then set signs.
    always_comb begin
        n_qctl = r_dl[COS_LAT].ctl;
        n_a    = r_s_pad[SIN_PAD-1];
        n_b    = c_t[COS_STEPS-1];
        n_s0   = n_qctl.swap ? n_b : n_a;
        n_c0   = n_qctl.swap ? n_a : n_b;
        n_s0s  = $signed({1'b0, n_s0});
        n_c0s  = $signed({1'b0, n_c0});
        case (n_qctl.quad)
            QUAD_FIRST: begin
                n_sin = n_s0s;
                n_cos = n_c0s;
            end
            QUAD_SECOND: begin
                n_sin = n_c0s;
                n_cos = -n_s0s;
            end
            QUAD_THIRD: begin
                n_sin = -n_s0s;
                n_cos = -n_c0s;
            end
            default: begin
                n_sin = -n_c0s;
                n_cos = n_s0s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Radians and their square.
            r_k0_f   <= n_k0_f;
            r_k0_ctl <= '{quad: i_phase[PHASE_BITS-1:PHASE_BITS-2],
                          swap: i_phase[Q30_BITS-1], rad: '0};
            r_k1_mr  <= (2*Q30_BITS+2)'(r_k0_f) * (2*Q30_BITS+2)'(PI_Q30);
            r_k1_ctl <= r_k0_ctl;
            r_k2_ctl <= '{quad: r_k1_ctl.quad, swap: r_k1_ctl.swap,
                          rad: Q30_BITS'((r_k1_mr + (2*Q30_BITS+2)'(Q30_ONE)) >> 31)};
            r_k3_rr  <= (2*Q30_BITS)'(r_k2_ctl.rad) * (2*Q30_BITS)'(r_k2_ctl.rad);
            r_k3_ctl <= r_k2_ctl;
            r_dl[0]  <= '{ctl: r_k3_ctl,
                          x2: Q30_BITS'((r_k3_rr + (2*Q30_BITS)'(Q30_HALF)) >> 30)};
            for (int i = 1; i <= COS_LAT; i++) r_dl[i] <= r_dl[i-1];

            // Cosine chain: multiply, round, reciprocal, correct.
            for (int j = 0; j < COS_STEPS; j++) begin
                c_p1[j] <= (2*Q30_BITS+1)'(r_dl[STEP_LAT*j].x2)
                         * (2*Q30_BITS+1)'(n_ct_in[j]);
                c_p[j]  <= Q30_BITS'((c_p1[j] + (2*Q30_BITS+1)'(Q30_HALF)) >> 30);
                c_pm[j] <= (2*Q30_BITS+2)'(c_p[j]) * (2*Q30_BITS+2)'(COS_M[j]);
                c_pc[j] <= c_p[j];
                c_t[j]  <= n_c_t[j];
            end

            // Sine chain, the same steps with its own constants.
            for (int j = 0; j < SIN_STEPS; j++) begin
                s_p1[j] <= (2*Q30_BITS+1)'(r_dl[STEP_LAT*j].x2)
                         * (2*Q30_BITS+1)'(n_st_in[j]);
                s_p[j]  <= Q30_BITS'((s_p1[j] + (2*Q30_BITS+1)'(Q30_HALF)) >> 30);
                s_pm[j] <= (2*Q30_BITS+2)'(s_p[j]) * (2*Q30_BITS+2)'(SIN_M[j]);
                s_pc[j] <= s_p[j];
                s_t[j]  <= n_s_t[j];
            end

            // Sine times radians, then delay to meet the cosine.
            r_s_mul <= (2*Q30_BITS+1)'(r_dl[SIN_LAT].ctl.rad)
                     * (2*Q30_BITS+1)'(s_t[SIN_STEPS-1]);
            r_s_val <= (Q30_BITS+1)'((r_s_mul + (2*Q30_BITS+1)'(Q30_HALF)) >> 30);
            r_s_pad[0] <= r_s_val;
            for (int i = 1; i < SIN_PAD; i++) r_s_pad[i] <= r_s_pad[i-1];

            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule
`default_nettype wire

>>> design/usp_coord.sv
// Coordinate products, rounding and saturation to signed Q1.15.
`default_nettype none
module usp_coord import usp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [TRIG_BITS-1:0]  i_sin_t,
    input  logic signed [TRIG_BITS-1:0]  i_cos_t,
    input  logic signed [TRIG_BITS-1:0]  i_sin_p,
    input  logic signed [TRIG_BITS-1:0]  i_cos_p,
    output logic signed [COORD_BITS-1:0] o_pos_x,
    output logic signed [COORD_BITS-1:0] o_pos_y,
    output logic signed [COORD_BITS-1:0] o_pos_z
);

    logic signed [2*TRIG_BITS-1:0] r_px, r_pz;
    logic signed [TRIG_BITS-1:0]   r_py;
    logic signed [COORD_BITS-1:0]  r_x, r_y, r_z;

    // Round half away from zero by sh bits and saturate to the coordinate range.
    function automatic logic [COORD_BITS-1:0] round_sat(input logic signed [63:0] v,
                                                        input int unsigned sh);
        logic        neg;
        logic [63:0] mag;
        neg = v[63];
        mag = neg ? 64'(-v) : 64'(v);
        if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (neg) begin
            if (mag > (64'd1 << (COORD_BITS - 1))) mag = 64'd1 << (COORD_BITS - 1);
            round_sat = COORD_BITS'((64'd1 << COORD_BITS) - mag);
        end else begin
            if (mag > ((64'd1 << (COORD_BITS - 1)) - 64'd1))
                mag = (64'd1 << (COORD_BITS - 1)) - 64'd1;
            round_sat = mag[COORD_BITS-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px <= i_cos_p * i_sin_t;
            r_pz <= i_sin_p * i_sin_t;
            r_py <= -i_cos_t;
            r_x  <= $signed(round_sat(r_px, XZ_SHIFT));
            r_z  <= $signed(round_sat(r_pz, XZ_SHIFT));
            r_y  <= $signed(round_sat(64'(r_py), Y_SHIFT));
        end
    end

    assign o_pos_x = r_x;
    assign o_pos_y = r_y;
    assign o_pos_z = r_z;

endmodule
`default_nettype wire

>>> design/uv_sphere_point_and_quad.sv
// Top level of the sphere point and quad generator.
`default_nettype none
`include "uv_sphere_point_and_quad_defines.svh"
// One grid position (ring, sector) goes in per cycle while the skid buffer is empty, and one
// result comes out per cycle while the output is ready: the unit-sphere point in signed
// Q1.15, the six triangle indices of the quad at that corner with a quad-valid flag, and an
// out-of-grid flag. The pipeline length is set by the two phase dividers (four quotient
// bits a stage) and the six-step cosine series of the sine and cosine units. A one-entry
// skid buffer behind the output register keeps the input accepting while a result waits;
// a second waiting result freezes the pipeline. The user must write the grid counts over
// the configuration port only while the block is idle; the block itself does not enforce
// it. A count below two acts as two and one above the grid limit acts as the limit.
module uv_sphere_point_and_quad import usp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [COUNT_BITS-1:0] i_cfg_data
);

    typedef struct packed {
        logic [POS_BITS-1:0]   ring;
        logic [POS_BITS-1:0]   sector;
        logic [COUNT_BITS-1:0] sn;
        logic [COUNT_BITS-1:0] th_den;
        logic [COUNT_BITS-1:0] th_half;
        logic [COUNT_BITS-1:0] ph_den;
        logic [COUNT_BITS-1:0] ph_half;
        logic                  oog;
        logic                  quad;
    } t_stage0;

    typedef struct packed {
        logic [INDEX_BITS-1:0] lo;
        logic [INDEX_BITS-1:0] hi;
        logic                  quad;
        logic                  oog;
    } t_side;

    logic [COUNT_BITS-1:0] r_rings, r_sectors;
    logic                  r_v0;
    t_stage0               r_s0;
    logic [LAT_SIDE-1:0]   r_vld;
    t_side                 r_side [LAT_SIDE];
    logic                  r_ov, r_sv;
    t_out_item             r_out, r_skid;

    logic                  w_en;
    logic [COUNT_BITS-1:0] w_rn, w_sn;
    logic [POS_BITS-1:0]   w_dr, w_ds;
    logic [PHASE_BITS-1:0] w_ph_t, w_ph_p;
    logic signed [TRIG_BITS-1:0] w_sin_t, w_cos_t, w_sin_p, w_cos_p;
    logic signed [COORD_BITS-1:0] w_x, w_y, w_z;
    t_stage0               n_s0;
    logic [INDEX_BITS:0]   n_lo, n_hi;
    t_out_item             n_item;
    t_side                 w_last;

    // Clamp a count to the supported grid.
    function automatic logic [COUNT_BITS-1:0] eff_count(input logic [COUNT_BITS-1:0] v);
        if (v < COUNT_BITS'(2)) eff_count = COUNT_BITS'(2);
        else if (v > COUNT_BITS'(GRID_LIMIT)) eff_count = COUNT_BITS'(GRID_LIMIT);
        else eff_count = v;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rings   <= RINGS_RESET;
            r_sectors <= SECTORS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RINGS:   r_rings   <= i_cfg_data;
                REG_SECTORS: r_sectors <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_rn = eff_count(r_rings);
    assign w_sn = eff_count(r_sectors);
    assign w_dr = POS_BITS'(w_rn - COUNT_BITS'(1));
    assign w_ds = POS_BITS'(w_sn - COUNT_BITS'(1));

    // The pipeline moves unless the skid buffer holds a result.
    assign w_en       = !r_sv;
    assign o_in_ready = w_en;

    // Input stage: grid tests and divider operands.
    always_comb begin
        n_s0.ring    = i_in_data.ring;
        n_s0.sector  = i_in_data.sector;
        n_s0.sn      = w_sn;
        n_s0.th_den  = {w_dr, 1'b0};
        n_s0.th_half = {1'b0, w_dr[POS_BITS-1:1], 1'b0};
        n_s0.ph_den  = {1'b0, w_ds};
        n_s0.ph_half = {2'b0, w_ds[POS_BITS-1:1]};
        n_s0.oog     = ({1'b0, i_in_data.ring} >= w_rn) || ({1'b0, i_in_data.sector} >= w_sn);
        n_s0.quad    = (i_in_data.ring < w_dr) && (i_in_data.sector < w_ds);
    end

    // Quad corner indices, kept to 16 bits.
    always_comb begin
        n_lo = (INDEX_BITS+1)'(r_s0.ring) * (INDEX_BITS+1)'(r_s0.sn)
             + (INDEX_BITS+1)'(r_s0.sector);
        n_hi = n_lo + (INDEX_BITS+1)'(r_s0.sn);
    end

    // Valid bits and side data travel alongside the arithmetic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vld <= '0;
        end else if (w_en) begin
            r_v0  <= i_in_valid;
            r_vld <= {r_vld[LAT_SIDE-2:0], r_v0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0      <= n_s0;
            r_side[0] <= '{lo: n_lo[INDEX_BITS-1:0], hi: n_hi[INDEX_BITS-1:0],
                           quad: r_s0.quad, oog: r_s0.oog};
            for (int i = 1; i < LAT_SIDE; i++) r_side[i] <= r_side[i-1];
        end
    end

    // Phase of latitude and longitude.
    usp_phase_div u_div_theta (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_s0.ring),
        .i_den   (r_s0.th_den),
        .i_half  (r_s0.th_half),
        .o_phase (w_ph_t)
    );

    usp_phase_div u_div_phi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (r_s0.sector),
        .i_den   (r_s0.ph_den),
        .i_half  (r_s0.ph_half),
        .o_phase (w_ph_p)
    );

    // Sine and cosine of both angles.
    usp_sincos u_sc_theta (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph_t),
        .o_sin   (w_sin_t),
        .o_cos   (w_cos_t)
    );

    usp_sincos u_sc_phi (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (w_ph_p),
        .o_sin   (w_sin_p),
        .o_cos   (w_cos_p)
    );

    usp_coord u_coord (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_sin_t (w_sin_t),
        .i_cos_t (w_cos_t),
        .i_sin_p (w_sin_p),
        .i_cos_p (w_cos_p),
        .o_pos_x (w_x),
        .o_pos_y (w_y),
        .o_pos_z (w_z)
    );

    // Result assembly: outside the grid everything is zero but the flag.
    always_comb begin
        w_last = r_side[LAT_SIDE-1];
        n_item = '0;
        if (w_last.oog) begin
            n_item.out_of_grid = 1'b1;
        end else begin
            n_item.pos_x = w_x;
            n_item.pos_y = w_y;
            n_item.pos_z = w_z;
            if (w_last.quad) begin
                n_item.index_a    = w_last.lo;
                n_item.index_b    = w_last.hi + INDEX_BITS'(1);
                n_item.index_c    = w_last.lo + INDEX_BITS'(1);
                n_item.index_d    = w_last.hi + INDEX_BITS'(1);
                n_item.index_e    = w_last.lo;
                n_item.index_f    = w_last.hi;
                n_item.quad_valid = 1'b1;
            end
        end
    end

    // Output register with a one-entry skid buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_out_ready) r_sv <= 1'b0;
        end else if (r_ov && !i_out_ready) begin
            if (r_vld[LAT_SIDE-1]) r_sv <= 1'b1;
        end else begin
            r_ov <= r_vld[LAT_SIDE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (i_out_ready) r_out <= r_skid;
        end else if (r_ov && !i_out_ready) begin
            r_skid <= n_item;
        end else begin
            r_out <= n_item;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    `USP_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_sv |-> r_ov, "skid holds a result while the output register is empty")
    `USP_ASSERT_NEXT(a_frozen_on_skid, i_clk, i_rst_n, r_sv, $stable(r_vld), "pipeline moved while the skid buffer was full")
    `USP_ASSERT(a_oog_clean, i_clk, i_rst_n, (o_out_valid && o_out_data.out_of_grid) |-> (!o_out_data.quad_valid && o_out_data.pos_x == 0 && o_out_data.index_a == 0), "out-of-grid result carries data")

endmodule
`default_nettype wire

>>> tb/sv/tb_uv_sphere_point_and_quad.sv
// Self-checking testbench of the sphere point and quad generator.
module tb_uv_sphere_point_and_quad;
    import usp_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [COUNT_BITS-1:0] i_cfg_data;

    // Predictor copies of the grid counts.
    logic [COUNT_BITS-1:0] rings_reg;
    logic [COUNT_BITS-1:0] sectors_reg;

    t_out_item expected_points[$];
    int        errors;
    bit        stall_enable;

    uv_sphere_point_and_quad dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

    // Clamp of a grid count to the legal range.
    function automatic longint unsigned clamp_count(logic [COUNT_BITS-1:0] v);
        if (v < 2) return 2;
        if (v > GRID_LIMIT) return GRID_LIMIT;
        return v;
    endfunction

    // Taylor sine and cosine in Q30 of an offset f in [0, 2^29].
    task automatic taylor_q30(input longint unsigned f,
                              output longint unsigned s, output longint unsigned c);
        longint unsigned sk[5];
        longint unsigned ck[6];
        longint unsigned r, x2, t;
        sk = '{110, 72, 42, 20, 6};
        ck = '{132, 90, 56, 30, 12, 2};
        r  = (f * 64'd3373259426 + (64'd1 << 30)) >> 31;
        x2 = (r * r + (64'd1 << 29)) >> 30;
        t  = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
            t = (64'd1 << 30) - (((x2 * t + (64'd1 << 29)) >> 30) / sk[i]);
        s = (r * t + (64'd1 << 29)) >> 30;
        t = 64'd1 << 30;
        for (int i = 0; i < 6; i++)
            t = (64'd1 << 30) - (((x2 * t + (64'd1 << 29)) >> 30) / ck[i]);
        c = t;
    endtask

    // Sine and cosine of a 32-bit phase, with quadrant folding.
    task automatic phase_sincos(input logic [31:0] p, output longint sv, output longint cv);
        longint unsigned u, a, b;
        longint s0, c0;
        u = p[29:0];
        if (u < (64'd1 << 29)) begin
            taylor_q30(u, a, b);
            s0 = a;
            c0 = b;
        end else begin
            taylor_q30((64'd1 << 30) - u, a, b);
            s0 = b;
            c0 = a;
        end
        case (p[31:30])
            QUAD_FIRST: begin
                sv = s0; cv = c0;
            end
            QUAD_SECOND: begin
                sv = c0; cv = -s0;
            end
            QUAD_THIRD: begin
                sv = -s0; cv = -c0;
            end
            default: begin
                sv = -c0; cv = s0;
            end
        endcase
    endtask

    // Rounding half away from zero, then saturation to 16 bits.
    function automatic logic [15:0] round_coord(longint v, int sh);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        if (v < 0) begin
            if (mag > 32768) mag = 32768;
            return 16'(65536 - mag);
        end
        if (mag > 32767) mag = 32767;
        return 16'(mag);
    endfunction

    // Expected point and quad for one grid position.
    task automatic predict_point(input t_in_item it, output t_out_item o);
        longint unsigned rn, sn, r, s, dr, ds, lo, hi;
        logic [31:0] pt, pp;
        longint st, ct, sp, cp;
        rn = clamp_count(rings_reg);
        sn = clamp_count(sectors_reg);
        r  = it.ring;
        s  = it.sector;
        dr = rn - 1;
        ds = sn - 1;
        o  = '0;
        if (r >= rn || s >= sn) begin
            o.out_of_grid = 1'b1;
            return;
        end
        pt = 32'(((r << 31) + dr / 2) / dr);
        pp = 32'(((s << 32) + ds / 2) / ds);
        phase_sincos(pt, st, ct);
        phase_sincos(pp, sp, cp);
        o.pos_x = round_coord(cp * st, 60 - COORD_FRAC_BITS);
        o.pos_y = round_coord(-ct, 30 - COORD_FRAC_BITS);
        o.pos_z = round_coord(sp * st, 60 - COORD_FRAC_BITS);
        if (r < dr && s < ds) begin
            lo = r * sn + s;
            hi = (r + 1) * sn + s;
            o.index_a = 16'(lo);
            o.index_b = 16'(hi + 1);
            o.index_c = 16'(lo + 1);
            o.index_d = 16'(hi + 1);
            o.index_e = 16'(lo);
            o.index_f = 16'(hi);
            o.quad_valid = 1'b1;
        end
    endtask

    // Random gap length: mostly short, now and then long.
    function automatic int gap_cycles();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Sends one grid position and records its expected result on transfer.
    // Valid stays high from one item to the next when there is no gap between them.
    task automatic send_position(input logic [7:0] ring, input logic [7:0] sector);
        t_in_item  it;
        t_out_item exp_item;
        int        g;
        g = stall_enable ? gap_cycles() : 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        it.ring = ring;
        it.sector = sector;
        i_in_data  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_point(it, exp_item);
        expected_points = {expected_points, exp_item};
        @(negedge i_clk);
    endtask

    // Writes a grid count once the pipeline has drained.
    task automatic write_count(input logic [1:0] idx, input logic [COUNT_BITS-1:0] val);
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (LAT_SIDE + 8) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_RINGS) rings_reg = val;
        else if (idx == REG_SECTORS) sectors_reg = val;
    endtask

    // Output stall driver.
    initial begin
        int g;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            g = (stall_enable && $urandom_range(0, 2) == 0) ? gap_cycles() : 0;
            if (g > 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Result checker.
    initial begin
        t_out_item e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected result %p", o_out_data);
                    errors++;
                end else begin
                    e = expected_points.pop_front();
                    if (o_out_data.pos_x !== e.pos_x) begin
                        $error("pos_x expected %0d got %0d", e.pos_x, o_out_data.pos_x);
                        errors++;
                    end
                    if (o_out_data.pos_y !== e.pos_y) begin
                        $error("pos_y expected %0d got %0d", e.pos_y, o_out_data.pos_y);
                        errors++;
                    end
                    if (o_out_data.pos_z !== e.pos_z) begin
                        $error("pos_z expected %0d got %0d", e.pos_z, o_out_data.pos_z);
                        errors++;
                    end
                    if (o_out_data.index_a !== e.index_a) begin
                        $error("index_a expected %0d got %0d", e.index_a, o_out_data.index_a);
                        errors++;
                    end
                    if (o_out_data.index_b !== e.index_b) begin
                        $error("index_b expected %0d got %0d", e.index_b, o_out_data.index_b);
                        errors++;
                    end
                    if (o_out_data.index_c !== e.index_c) begin
                        $error("index_c expected %0d got %0d", e.index_c, o_out_data.index_c);
                        errors++;
                    end
                    if (o_out_data.index_d !== e.index_d) begin
                        $error("index_d expected %0d got %0d", e.index_d, o_out_data.index_d);
                        errors++;
                    end
                    if (o_out_data.index_e !== e.index_e) begin
                        $error("index_e expected %0d got %0d", e.index_e, o_out_data.index_e);
                        errors++;
                    end
                    if (o_out_data.index_f !== e.index_f) begin
                        $error("index_f expected %0d got %0d", e.index_f, o_out_data.index_f);
                        errors++;
                    end
                    if (o_out_data.quad_valid !== e.quad_valid) begin
                        $error("quad_valid expected %0d got %0d", e.quad_valid,
                               o_out_data.quad_valid);
                        errors++;
                    end
                    if (o_out_data.out_of_grid !== e.out_of_grid) begin
                        $error("out_of_grid expected %0d got %0d", e.out_of_grid,
                               o_out_data.out_of_grid);
                        errors++;
                    end
                end
            end
        end
    end

    // Directed corners with the reset grid, then clamped and unknown-index writes.
    task automatic test_directed();
        stall_enable = 1'b0;
        send_position(8'd0, 8'd0);
        send_position(8'd15, 8'd15);
        send_position(8'd14, 8'd14);
        send_position(8'd15, 8'd0);
        send_position(8'd0, 8'd15);
        send_position(8'd16, 8'd0);
        send_position(8'd0, 8'd16);
        send_position(8'd255, 8'd255);
        send_position(8'd7, 8'd4);
        send_position(8'd8, 8'd12);
        // Counts below two act as two.
        write_count(REG_RINGS, 9'd0);
        write_count(REG_SECTORS, 9'd1);
        send_position(8'd0, 8'd0);
        send_position(8'd1, 8'd1);
        send_position(8'd2, 8'd0);
        // Counts above the limit act as the limit.
        write_count(REG_RINGS, 9'd511);
        write_count(REG_SECTORS, 9'd300);
        send_position(8'd255, 8'd255);
        send_position(8'd254, 8'd254);
        send_position(8'd128, 8'd170);
        send_position(8'd85, 8'd64);
        // An unknown register index changes nothing.
        write_count(2'd3, 9'd5);
        write_count(2'd2, 9'd3);
        send_position(8'd254, 8'd0);
        send_position(8'd0, 8'd254);
    endtask

    // Random positions over several grid settings, with idling on both sides.
    task automatic test_random_grids();
        logic [COUNT_BITS-1:0] rc, sc;
        logic [7:0] r, s;
        stall_enable = 1'b1;
        for (int ph = 0; ph < 13; ph++) begin
            case (ph)
                0: begin rc = 9'd2; sc = 9'd2; end
                1: begin rc = 9'd256; sc = 9'd256; end
                2: begin rc = 9'd257; sc = 9'd3; end
                3: begin rc = 9'd3; sc = 9'd511; end
                default: begin
                    rc = 9'($urandom_range(0, 511));
                    sc = 9'($urandom_range(0, 511));
                end
            endcase
            write_count(REG_RINGS, rc);
            write_count(REG_SECTORS, sc);
            for (int n = 0; n < 150; n++) begin
                // Mostly positions inside the grid; the rest anywhere.
                if ($urandom_range(0, 4) != 0) begin
                    r = 8'($urandom_range(0, 32'(clamp_count(rc) - 1)));
                    s = 8'($urandom_range(0, 32'(clamp_count(sc) - 1)));
                end else begin
                    r = 8'($urandom_range(0, 255));
                    s = 8'($urandom_range(0, 255));
                end
                send_position(r, s);
            end
        end
        stall_enable = 1'b0;
    endtask

    // Main sequence.
    initial begin
        errors       = 0;
        stall_enable = 1'b0;
        rings_reg    = RINGS_RESET;
        sectors_reg  = SECTORS_RESET;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_RINGS;
        i_cfg_data   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_grids();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge i_clk);
        repeat (LAT_SIDE + 8) @(negedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/usp_pkg.sv
design/usp_phase_div.sv
design/usp_sincos.sv
design/usp_coord.sv
design/uv_sphere_point_and_quad.sv
tb/sv/tb_uv_sphere_point_and_quad.sv
